/* src/dpfe_pkg.sv */
// ---------------------------------------------------------------------------
// dpfe_pkg: shared constants for the distinct prime factor engine
// Widths of the value, trial divisor, square bound and counters.
// ---------------------------------------------------------------------------
package dpfe_pkg;

  // Input and factor field widths
  localparam int VALUE_FIELD_BITS = 32;
  localparam int FACTOR_BITS      = 32;

  // Number of low bits of the input value that are factored
  localparam int VALUE_BITS = 32;

  // Trial divisor stays at or below sqrt(2^VALUE_BITS) + 2
  localparam int D_BITS  = VALUE_BITS / 2 + 1;
  // Square of the trial divisor, with headroom for the last step
  localparam int SQ_BITS = VALUE_BITS + 2;

  // Bit counter of the serial divider
  localparam int BIT_CNT_BITS = $clog2(VALUE_BITS);

  // Result count cap
  localparam int MAX_RESULTS = 9;
  localparam int RES_CNT_BITS = $clog2(MAX_RESULTS + 1);

  // Trial division starting point
  localparam int FIRST_ODD = 3;

endpackage

/* src/distinct_prime_factor_engine_top.sv */
// ---------------------------------------------------------------------------
// distinct_prime_factor_engine_top: distinct prime factors by trial division
// Emits the distinct primes of each request in increasing order.
// ---------------------------------------------------------------------------
// One request is worked on at a time; value_stall is high from acceptance
// until the final result has been placed in the output register. Factors of
// two are shifted out one per cycle. Each odd trial divisor d then takes a
// bound check of d*d against the remainder, a bit-serial restoring divider
// producing one quotient bit per cycle and an evaluation step; every
// successful division reruns the divider, and a newly found prime first
// emits the older pending one, which can wait on result_stall.
// A 32-bit prime near 2^32 runs through 32767 odd trial divisors, each
// through the serial divider. Inputs 0 and 1 produce one result
// with has_factor low. The output register lets the next request be
// accepted while the final result still waits on result_stall.
module distinct_prime_factor_engine_top
  import dpfe_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        value_valid,
  output logic                        value_stall,
  input  logic [VALUE_FIELD_BITS-1:0] value,
  // result channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [FACTOR_BITS-1:0]      factor,
  output logic                        has_factor,
  output logic                        last
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_NOF      = 8'b0000_0010,
    S_STRIP    = 8'b0000_0100,
    S_CHECK    = 8'b0000_1000,
    S_DIV      = 8'b0001_0000,
    S_EVAL     = 8'b0010_0000,
    S_PUSH     = 8'b0100_0000,
    S_FIN_PEND = 8'b1000_0000
  } state_t;

  state_t                  state;
  logic                    fin_rem;      // final remainder result still due
  logic [VALUE_BITS-1:0]   rem;          // remaining value
  logic [VALUE_BITS-1:0]   div_reg;      // dividend shifting out, quotient in
  logic [D_BITS-1:0]       part;         // partial remainder
  logic [D_BITS-1:0]       d;            // trial divisor
  logic [SQ_BITS-1:0]      sq;           // d * d
  logic [BIT_CNT_BITS-1:0] bit_cnt;
  logic                    d_hit;        // d already recorded
  logic [VALUE_BITS-1:0]   pend;         // found prime not yet emitted
  logic                    pend_valid;
  logic [RES_CNT_BITS-1:0] res_cnt;

  logic                    out_free;
  logic                    out_load;
  logic [D_BITS:0]         trial;
  logic                    trial_ge;
  logic [D_BITS-1:0]       part_next;
  logic                    rem_prime;

  // output slot is free if empty or being taken this cycle
  assign out_free    = !result_valid || !result_stall;
  assign value_stall = (state != S_IDLE);

  // one restoring division step
  assign trial     = {part, div_reg[VALUE_BITS-1]};
  assign trial_ge  = (trial >= {1'b0, d});
  assign part_next = trial_ge ? D_BITS'(trial - {1'b0, d}) : trial[D_BITS-1:0];

  // leftover remainder is a prime of its own
  assign rem_prime = (rem > VALUE_BITS'(2)) && (res_cnt < RES_CNT_BITS'(MAX_RESULTS));

  // a new result enters the output register this cycle
  assign out_load = out_free &&
                    ((state == S_NOF) || (state == S_PUSH) ||
                     ((state == S_FIN_PEND) && (fin_rem || !rem_prime || pend_valid)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      fin_rem      <= 1'b0;
      pend_valid   <= 1'b0;
      res_cnt      <= '0;
      d_hit        <= 1'b0;
      bit_cnt      <= '0;
    end else begin
      // output register drains when taken and not reloaded
      if (result_valid && !result_stall && !out_load) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (value_valid) begin
            rem        <= VALUE_BITS'(value);
            pend_valid <= 1'b0;
            res_cnt    <= '0;
            fin_rem    <= 1'b0;
            d          <= D_BITS'(FIRST_ODD);
            sq         <= SQ_BITS'(FIRST_ODD * FIRST_ODD);
            if (VALUE_BITS'(value) < VALUE_BITS'(2)) begin
              state <= S_NOF;
            end else begin
              state <= S_STRIP;
            end
          end
        end

        // no prime factor: single marked result
        S_NOF: begin
          if (out_free) begin
            result_valid <= 1'b1;
            factor       <= '0;
            has_factor   <= 1'b0;
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end

        // shift out factors of two, record two once
        S_STRIP: begin
          if (!rem[0]) begin
            if (!pend_valid) begin
              pend_valid <= 1'b1;
              pend       <= VALUE_BITS'(2);
              res_cnt    <= RES_CNT_BITS'(1);
            end
            rem <= rem >> 1;
          end else begin
            state <= S_CHECK;
          end
        end

        // bound check d*d <= rem: start a division if it holds, else finish
        S_CHECK: begin
          d_hit <= 1'b0;
          if (sq <= {2'b00, rem}) begin
            div_reg <= rem;
            part    <= '0;
            bit_cnt <= '0;
            state   <= S_DIV;
          end else begin
            state <= S_FIN_PEND;
          end
        end

        // bit-serial restoring division, MSB first
        S_DIV: begin
          part    <= part_next;
          div_reg <= {div_reg[VALUE_BITS-2:0], trial_ge};
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == BIT_CNT_BITS'(VALUE_BITS - 1)) begin
            state <= S_EVAL;
          end
        end

        // exact division keeps d, else move to the next odd divisor
        S_EVAL: begin
          if (part == '0) begin
            rem     <= div_reg;
            part    <= '0;
            bit_cnt <= '0;
            d_hit   <= 1'b1;
            if (!d_hit && (res_cnt < RES_CNT_BITS'(MAX_RESULTS))) begin
              res_cnt <= res_cnt + 1'b1;
              if (pend_valid) begin
                state <= S_PUSH;
              end else begin
                pend       <= VALUE_BITS'(d);
                pend_valid <= 1'b1;
                state      <= S_DIV;
              end
            end else begin
              state <= S_DIV;
            end
          end else begin
            d     <= d + D_BITS'(2);
            sq    <= sq + SQ_BITS'({d, 2'b00}) + SQ_BITS'(4);
            state <= S_CHECK;
          end
        end

        // emit the older prime, hold the new one; div_reg keeps the quotient
        S_PUSH: begin
          if (out_free) begin
            result_valid <= 1'b1;
            factor       <= FACTOR_BITS'(pend);
            has_factor   <= 1'b1;
            last         <= 1'b0;
            pend         <= VALUE_BITS'(d);
            state        <= S_DIV;
          end
        end

        // end of trial division: emit any pending prime, then the remainder if prime
        S_FIN_PEND: begin
          if (fin_rem) begin
            if (out_free) begin
              result_valid <= 1'b1;
              factor       <= FACTOR_BITS'(rem);
              has_factor   <= 1'b1;
              last         <= 1'b1;
              fin_rem      <= 1'b0;
              state        <= S_IDLE;
            end
          end else if (rem_prime) begin
            // commit only once the pending prime can leave
            if (!pend_valid || out_free) begin
              res_cnt <= res_cnt + 1'b1;
              fin_rem <= 1'b1;
              if (pend_valid) begin
                result_valid <= 1'b1;
                factor       <= FACTOR_BITS'(pend);
                has_factor   <= 1'b1;
                last         <= 1'b0;
                pend_valid   <= 1'b0;
              end
            end
          end else if (out_free) begin
            result_valid <= 1'b1;
            factor       <= FACTOR_BITS'(pend);
            has_factor   <= 1'b1;
            last         <= 1'b1;
            pend_valid   <= 1'b0;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // divider partial remainder stays below the divisor
  a_part_below_d : assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (part < d))
    else $error("partial remainder not below divisor");

  // trial division only runs on an odd remainder
  a_rem_odd : assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> rem[0])
    else $error("even remainder reached trial division");

  // a result without a factor is always the final one
  a_nof_last : assert property (@(posedge clk) disable iff (rst)
    (result_valid && !has_factor) |-> last)
    else $error("factorless result not marked last");

  // result count never exceeds the cap
  a_cnt_cap : assert property (@(posedge clk) disable iff (rst)
    res_cnt <= RES_CNT_BITS'(MAX_RESULTS))
    else $error("result count above cap");

endmodule
